// ===== design/olist_pkg.sv =====
`timescale 1ns / 1ps
package olist_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int POS_W     = 9;
    localparam int CMD_W     = 3;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEDUP  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RDEL   = 3'd5;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [2:0] {
        OP_INSERT, OP_DELETE, OP_FIND, OP_COUNT, OP_DEDUP, OP_RDEL, OP_NOP
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        logic signed [VAL_W-1:0] hi;
    } job_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_INS_RD, BK_INS_WR, BK_DEL_RD, BK_DEL_WR, BK_SCAN_RD, BK_SCAN_CHK,
        BK_DUP_RD, BK_DUP_CUR, BK_DUP_KRD, BK_DUP_KCHK, BK_DONE
    } bk_state_t;

endpackage

// ===== design/olist_front.sv =====
`timescale 1ns / 1ps
module olist_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [olist_pkg::CMD_W-1:0]    s_command,
    input  logic [olist_pkg::POS_W-1:0]    s_position,
    input  logic signed [olist_pkg::VAL_W-1:0] s_value,
    input  logic signed [olist_pkg::VAL_W-1:0] s_range_high,
    output logic                           q_valid,
    output olist_pkg::job_t                q_job,
    input  logic                           q_pop
);
    import olist_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    job_t       job_in;
    logic       push, pop;

    // Decode the command code into an operation.
    always_comb begin
        job_in.pos = s_position;
        job_in.val = s_value;
        job_in.hi  = s_range_high;
        case (s_command)
            CMD_INSERT: job_in.op = OP_INSERT;
            CMD_DELETE: job_in.op = OP_DELETE;
            CMD_FIND:   job_in.op = OP_FIND;
            CMD_COUNT:  job_in.op = OP_COUNT;
            CMD_DEDUP:  job_in.op = OP_DEDUP;
            CMD_RDEL:   job_in.op = OP_RDEL;
            default:    job_in.op = OP_NOP;
        endcase
    end

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_job   = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== design/olist_back.sv =====
`timescale 1ns / 1ps
module olist_back #(
    parameter int DEPTH = olist_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  olist_pkg::job_t               q_job,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [olist_pkg::POS_W-1:0]   m_answer,
    output logic [olist_pkg::POS_W-1:0]   m_length,
    output logic [olist_pkg::ST_W-1:0]    m_status
);
    import olist_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > POS_W) ? CW + 1 : POS_W + 1;

    logic signed [VAL_W-1:0] mem [DEPTH];

    bk_state_t               state_reg, state_next;
    job_t                    job_reg, job_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           wr_reg, wr_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [CW-1:0]           ans_reg, ans_next;
    logic [ST_W-1:0]         st_reg, st_next;
    logic signed [VAL_W-1:0] cur_reg, cur_next;
    logic signed [VAL_W-1:0] rdata_reg;

    logic                    m_valid_reg;
    logic [POS_W-1:0]        m_answer_reg, m_length_reg;
    logic [ST_W-1:0]         m_status_reg;

    logic                    we;
    logic [CW-1:0]           waddr, raddr;
    logic signed [VAL_W-1:0] wdata;
    logic                    out_free, out_load, in_range;
    logic [WW-1:0]           qpos_w, jpos_w, cnt_w, idx_w;

    assign out_free = !m_valid_reg || m_ready;
    assign qpos_w   = WW'(q_job.pos);
    assign jpos_w   = WW'(job_reg.pos);
    assign cnt_w    = WW'(count_reg);
    assign idx_w    = WW'(idx_reg);
    assign in_range = (rdata_reg >= job_reg.val) && (rdata_reg <= job_reg.hi);

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        wr_next    = wr_reg;
        k_next     = k_reg;
        ans_next   = ans_reg;
        st_next    = st_reg;
        cur_next   = cur_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = rdata_reg;
        raddr      = '0;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    ans_next = '0;
                    st_next  = ST_OK;
                    idx_next = '0;
                    wr_next  = '0;
                    case (q_job.op)
                        OP_INSERT: begin
                            if (qpos_w == '0 || qpos_w > cnt_w + WW'(1)) begin
                                st_next    = ST_BAD_POS;
                                state_next = BK_DONE;
                            end else if (cnt_w == WW'(DEPTH)) begin
                                st_next    = ST_FULL;
                                state_next = BK_DONE;
                            end else begin
                                idx_next   = count_reg;
                                state_next = BK_INS_RD;
                            end
                        end
                        OP_DELETE: begin
                            if (qpos_w == '0 || qpos_w > cnt_w) begin
                                st_next    = ST_BAD_POS;
                                state_next = BK_DONE;
                            end else begin
                                idx_next   = CW'(qpos_w - WW'(1));
                                state_next = BK_DEL_RD;
                            end
                        end
                        OP_FIND, OP_COUNT, OP_RDEL: state_next = BK_SCAN_RD;
                        OP_DEDUP:                   state_next = BK_DUP_RD;
                        default:                    state_next = BK_DONE;
                    endcase
                end
            end
            BK_INS_RD: begin
                if (idx_w >= jpos_w) begin
                    raddr      = idx_reg - CW'(1);
                    state_next = BK_INS_WR;
                end else begin
                    we         = 1'b1;
                    wdata      = job_reg.val;
                    count_next = count_reg + CW'(1);
                    state_next = BK_DONE;
                end
            end
            BK_INS_WR: begin
                we         = 1'b1;
                idx_next   = idx_reg - CW'(1);
                state_next = BK_INS_RD;
            end
            BK_DEL_RD: begin
                if (idx_w + WW'(1) < cnt_w) begin
                    raddr      = idx_reg + CW'(1);
                    state_next = BK_DEL_WR;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = BK_DONE;
                end
            end
            BK_DEL_WR: begin
                we         = 1'b1;
                idx_next   = idx_reg + CW'(1);
                state_next = BK_DEL_RD;
            end
            BK_SCAN_RD: begin
                if (idx_reg < count_reg) begin
                    raddr      = idx_reg;
                    state_next = BK_SCAN_CHK;
                end else begin
                    if (job_reg.op == OP_RDEL) count_next = wr_reg;
                    state_next = BK_DONE;
                end
            end
            BK_SCAN_CHK: begin
                idx_next   = idx_reg + CW'(1);
                state_next = BK_SCAN_RD;
                case (job_reg.op)
                    OP_FIND: begin
                        if (rdata_reg == job_reg.val) begin
                            ans_next   = idx_reg + CW'(1);
                            state_next = BK_DONE;
                        end
                    end
                    OP_COUNT: begin
                        if (in_range) ans_next = ans_reg + CW'(1);
                    end
                    default: begin
                        if (!in_range) begin
                            we      = 1'b1;
                            waddr   = wr_reg;
                            wr_next = wr_reg + CW'(1);
                        end
                    end
                endcase
            end
            BK_DUP_RD: begin
                if (idx_reg < count_reg) begin
                    raddr      = idx_reg;
                    state_next = BK_DUP_CUR;
                end else begin
                    count_next = wr_reg;
                    state_next = BK_DONE;
                end
            end
            BK_DUP_CUR: begin
                cur_next   = rdata_reg;
                k_next     = '0;
                state_next = BK_DUP_KRD;
            end
            BK_DUP_KRD: begin
                if (k_reg < wr_reg) begin
                    raddr      = k_reg;
                    state_next = BK_DUP_KCHK;
                end else begin
                    // First occurrence: keep it at the compacted tail.
                    we         = 1'b1;
                    waddr      = wr_reg;
                    wdata      = cur_reg;
                    wr_next    = wr_reg + CW'(1);
                    idx_next   = idx_reg + CW'(1);
                    state_next = BK_DUP_RD;
                end
            end
            BK_DUP_KCHK: begin
                if (rdata_reg == cur_reg) begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = BK_DUP_RD;
                end else begin
                    k_next     = k_reg + CW'(1);
                    state_next = BK_DUP_KRD;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr[AW-1:0]] <= wdata;
        end
        rdata_reg <= mem[raddr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        idx_reg <= idx_next;
        wr_reg  <= wr_next;
        k_reg   <= k_next;
        ans_reg <= ans_next;
        st_reg  <= st_next;
        cur_reg <= cur_next;
        if (out_load) begin
            m_answer_reg <= POS_W'(ans_reg);
            m_length_reg <= POS_W'(count_reg);
            m_status_reg <= st_reg;
        end
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_answer = m_answer_reg;
    assign m_length = m_length_reg;
    assign m_status = m_status_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds the store depth");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && st_reg == ST_FULL |-> cnt_w == WW'(DEPTH))
        else $error("store-full status reported with room left");

    a_write_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> waddr <= count_reg && WW'(waddr) < WW'(DEPTH))
        else $error("write beyond the end of the list");

    a_bad_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && st_reg != ST_OK |=> $stable(count_reg) || state_reg != BK_IDLE)
        else $error("rejected command changed the length");
`endif

endmodule

// ===== design/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// Insert and delete shift the entries past the position one at a time; find, count and
// range delete scan the list, and duplicate removal checks each entry against those kept.
// The back end takes one word at a time and starts the next only once a result is loaded;
// each shift step makes one registered read and one write of the entry memory.
// Reset (aresetn, synchronous, active low) empties the list and the two-word queue;
// the entry memory is not cleared, since only entries below the length are ever read.
module ordered_list_engine #(
    parameter int DEPTH = olist_pkg::DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [olist_pkg::CMD_W-1:0]        s_command,
    input  logic [olist_pkg::POS_W-1:0]        s_position,
    input  logic signed [olist_pkg::VAL_W-1:0] s_value,
    input  logic signed [olist_pkg::VAL_W-1:0] s_range_high,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [olist_pkg::POS_W-1:0]        m_answer,
    output logic [olist_pkg::POS_W-1:0]        m_length,
    output logic [olist_pkg::ST_W-1:0]         m_status
);
    import olist_pkg::*;

    // The front end decodes each word and parks it in a two-entry queue, so the
    // input side keeps taking words, while the queue has room, as the back end walks the list.
    logic q_valid, q_pop;
    job_t q_job;

    olist_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_position   (s_position),
        .s_value      (s_value),
        .s_range_high (s_range_high),
        .q_valid      (q_valid),
        .q_job        (q_job),
        .q_pop        (q_pop)
    );

    // The back end owns the entry memory and the length, checks positions against
    // the current length, runs the shift or scan, and holds the result in an
    // output register so it can start the next word while a result waits.
    olist_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_answer (m_answer),
        .m_length (m_length),
        .m_status (m_status)
    );

endmodule
